### rtl/qs_pkg.sv
// qs_pkg: shared constants and the sequencer state type of the quicksort engine.
// Used by the channel interfaces, the memories and the top level.
// No dependencies.
`default_nettype none

package qs_pkg;

  // Width of one element and of the sorted result.
  localparam int DATA_W = 32;

  // Default number of elements the local store holds.
  localparam int STORE_DEPTH_DEF = 64;

  // Smallest range that still needs partitioning.
  localparam int RANGE_MIN = 2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_PIVOT2,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SWAP_J,
    ST_FIN,
    ST_PUSH2,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } qs_state_t;

endpackage

`default_nettype wire

### rtl/qs_if.sv
// qs_if: valid/ready channel interfaces for the quicksort engine.
// qs_in_if carries unsorted elements, qs_out_if carries sorted results.
// Depends on qs_pkg.
`default_nettype none

interface qs_in_if import qs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface qs_out_if import qs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_result;
  logic                     overflow;

  modport source (output valid, output sorted_value, output last_result, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_result, input overflow,
                output ready);
endinterface

`default_nettype wire

### rtl/qs_store.sv
// qs_store: element memory with one write port and two registered read ports.
// The partition loop reads both scan pointers in the same cycle.
// Depends on qs_pkg.
`default_nettype none

module qs_store import qs_pkg::*; #(
  parameter int DEPTH  = STORE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]        raddr_a,
  input  wire logic [ADDR_W-1:0]        raddr_b,
  output logic signed [DATA_W-1:0]      rdata_a,
  output logic signed [DATA_W-1:0]      rdata_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### rtl/qs_stack.sv
// qs_stack: memory for the pending index ranges of the sort.
// One write port and one registered read port; the pointer lives in the sequencer.
// Depends on qs_pkg.
`default_nettype none

module qs_stack import qs_pkg::*; #(
  parameter int DEPTH   = STORE_DEPTH_DEF,
  parameter int ADDR_W  = $clog2(DEPTH),
  parameter int ENTRY_W = 2 * ADDR_W
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]  raddr,
  output logic [ENTRY_W-1:0]      rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/quicksort_engine.sv
// quicksort_engine: loads up to STORE_DEPTH elements, one transfer per cycle, then sorts
// them in place with quicksort and a range stack, then replays them in ascending order.
// Each pointer step reads both scan pointers from the two-port element memory and then compares
// them; each result is read from the store, loaded into the output register and held there until
// the sink takes it, so an output stall holds the replay. No input is taken meanwhile.
// Reset (synchronous, rst_n low) clears the count, the overflow flag and the sequencer.
`default_nettype none

module quicksort_engine import qs_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qs_in_if.sink     in_ch,
  qs_out_if.source  out_ch
);

  // Index widths. The scan pointer i may step one past the top of a range,
  // so it carries one extra bit; the count can hold the depth itself.
  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int EXT_W   = IDX_W + 1;
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int ENTRY_W = 2 * IDX_W;

  qs_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     drop_r, drop_nxt;
  logic [EXT_W-1:0]         sp_r, sp_nxt;
  logic [IDX_W-1:0]         lo_r, lo_nxt;
  logic [IDX_W-1:0]         hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt;
  logic [EXT_W-1:0]         i_r, i_nxt;
  logic [IDX_W-1:0]         j_r, j_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic signed [DATA_W-1:0] tmp_r, tmp_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;

  // Output register: the result waits here until the sink takes it.
  logic                     out_vld_r, out_vld_nxt;
  logic signed [DATA_W-1:0] out_val_r, out_val_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  // Element memory ports.
  logic                     st_we;
  logic [IDX_W-1:0]         st_waddr;
  logic signed [DATA_W-1:0] st_wdata;
  logic [IDX_W-1:0]         st_raddr_a;
  logic [IDX_W-1:0]         st_raddr_b;
  logic signed [DATA_W-1:0] st_rdata_a;
  logic signed [DATA_W-1:0] st_rdata_b;

  // Range stack ports.
  logic                     sk_we;
  logic [IDX_W-1:0]         sk_waddr;
  logic [ENTRY_W-1:0]       sk_wdata;
  logic [IDX_W-1:0]         sk_raddr;
  logic [ENTRY_W-1:0]       sk_rdata;

  qs_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (st_raddr_a),
    .raddr_b (st_raddr_b),
    .rdata_a (st_rdata_a),
    .rdata_b (st_rdata_b)
  );

  // Pending ranges are disjoint and hold two elements or more, so STORE_DEPTH
  // entries are always enough.
  qs_stack #(
    .DEPTH   (STORE_DEPTH),
    .ADDR_W  (IDX_W),
    .ENTRY_W (ENTRY_W)
  ) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  // Handshakes.
  logic in_fire;
  logic out_fire;

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.overflow     = out_ovf_r;
  assign out_fire            = out_ch.valid && out_ch.ready;

  // The shared compare unit of the partition loop. Both pointers scan at once:
  // i stops on an element above the pivot or past the range, j on one at or below it.
  logic store_full;
  logic i_in_range;
  logic i_adv;
  logic j_dec;
  logic i_lt_j;
  logic push_left;
  logic push_right;

  assign store_full = (cnt_r == CNT_W'(STORE_DEPTH));
  assign i_in_range = (i_r <= {1'b0, hi_r});
  assign i_adv      = i_in_range && (st_rdata_a <= key_r);
  assign j_dec      = (st_rdata_b > key_r);
  assign i_lt_j     = (i_r < {1'b0, j_r});
  assign push_left  = ({1'b0, j_r} >= ({1'b0, lo_r} + EXT_W'(RANGE_MIN)));
  assign push_right = (({1'b0, j_r} + EXT_W'(RANGE_MIN)) <= {1'b0, hi_r});

  // Range popped from the stack and its midpoint.
  logic [IDX_W-1:0] stk_lo;
  logic [IDX_W-1:0] stk_hi;
  logic [EXT_W-1:0] mid_sum;
  logic [IDX_W-1:0] stk_mid;

  assign stk_lo  = sk_rdata[ENTRY_W-1:IDX_W];
  assign stk_hi  = sk_rdata[IDX_W-1:0];
  assign mid_sum = {1'b0, stk_lo} + {1'b0, stk_hi};
  assign stk_mid = mid_sum[IDX_W:1];

  logic [CNT_W-1:0] cnt_dec;
  assign cnt_dec = cnt_r - CNT_W'(1);

  logic [IDX_W-1:0] j_dec_idx;
  logic [IDX_W-1:0] j_inc_idx;
  assign j_dec_idx = j_r - IDX_W'(1);
  assign j_inc_idx = j_r + IDX_W'(1);

  logic [EXT_W-1:0] sp_dec;
  assign sp_dec = sp_r - EXT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire && in_ch.last_item) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (cnt_r < CNT_W'(RANGE_MIN)) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_RANGE;
        end
      end
      ST_RANGE:   state_nxt = ST_PIVOT;
      ST_PIVOT:   state_nxt = ST_PIVOT2;
      ST_PIVOT2:  state_nxt = ST_SCAN_RD;
      ST_SCAN_RD: state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (i_adv || j_dec) begin
          state_nxt = ST_SCAN_RD;
        end else if (i_lt_j) begin
          state_nxt = ST_SWAP_J;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SWAP_J:  state_nxt = ST_SCAN_RD;
      ST_FIN: begin
        if (push_right) begin
          state_nxt = ST_PUSH2;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_PUSH2:   state_nxt = ST_POP;
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_fire) begin
          if (out_last_r) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Memory controls and datapath updates.
  always_comb begin
    cnt_nxt      = cnt_r;
    drop_nxt     = drop_r;
    sp_nxt       = sp_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    key_nxt      = key_r;
    tmp_nxt      = tmp_r;
    k_nxt        = k_r;
    out_vld_nxt  = out_vld_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;

    st_we      = 1'b0;
    st_waddr   = cnt_r[IDX_W-1:0];
    st_wdata   = in_ch.value;
    st_raddr_a = i_r[IDX_W-1:0];
    st_raddr_b = j_r;

    sk_we    = 1'b0;
    sk_waddr = sp_r[IDX_W-1:0];
    sk_wdata = {lo_r, j_dec_idx};
    sk_raddr = sp_dec[IDX_W-1:0];

    unique case (state_r)
      ST_LOAD: begin
        // A full store drops the item but still counts a last item.
        if (in_fire) begin
          if (store_full) begin
            drop_nxt = 1'b1;
          end else begin
            st_we    = 1'b1;
            st_waddr = cnt_r[IDX_W-1:0];
            st_wdata = in_ch.value;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_INIT: begin
        k_nxt = '0;
        if (cnt_r >= CNT_W'(RANGE_MIN)) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {IDX_W'(0), cnt_dec[IDX_W-1:0]};
          sp_nxt   = EXT_W'(1);
        end
      end
      ST_POP: begin
        if (sp_r != '0) begin
          sk_raddr = sp_dec[IDX_W-1:0];
          sp_nxt   = sp_dec;
        end
      end
      ST_RANGE: begin
        lo_nxt     = stk_lo;
        hi_nxt     = stk_hi;
        mid_nxt    = stk_mid;
        st_raddr_a = stk_lo;
        st_raddr_b = stk_mid;
      end
      ST_PIVOT: begin
        // Move the middle element to the bottom of the range as the pivot.
        st_we    = 1'b1;
        st_waddr = lo_r;
        st_wdata = st_rdata_b;
        key_nxt  = st_rdata_b;
        tmp_nxt  = st_rdata_a;
      end
      ST_PIVOT2: begin
        st_we    = 1'b1;
        st_waddr = mid_r;
        st_wdata = tmp_r;
        i_nxt    = {1'b0, lo_r} + EXT_W'(1);
        j_nxt    = hi_r;
      end
      ST_SCAN_RD: begin
        st_raddr_a = i_r[IDX_W-1:0];
        st_raddr_b = j_r;
      end
      ST_SCAN_EV: begin
        if (i_adv) begin
          i_nxt = i_r + EXT_W'(1);
        end
        if (j_dec) begin
          j_nxt = j_dec_idx;
        end
        if (!i_adv && !j_dec) begin
          if (i_lt_j) begin
            // First half of the exchange of the two stopped elements.
            st_we    = 1'b1;
            st_waddr = i_r[IDX_W-1:0];
            st_wdata = st_rdata_b;
            tmp_nxt  = st_rdata_a;
          end else begin
            // Pointers crossed: the element at j goes to the bottom.
            st_we    = 1'b1;
            st_waddr = lo_r;
            st_wdata = st_rdata_b;
          end
        end
      end
      ST_SWAP_J: begin
        st_we    = 1'b1;
        st_waddr = j_r;
        st_wdata = tmp_r;
      end
      ST_FIN: begin
        // The pivot lands at its final place; the lower part is pushed first.
        st_we    = 1'b1;
        st_waddr = j_r;
        st_wdata = key_r;
        if (push_left) begin
          sk_we    = 1'b1;
          sk_waddr = sp_r[IDX_W-1:0];
          sk_wdata = {lo_r, j_dec_idx};
          sp_nxt   = sp_r + EXT_W'(1);
        end
      end
      ST_PUSH2: begin
        if (push_right) begin
          sk_we    = 1'b1;
          sk_waddr = sp_r[IDX_W-1:0];
          sk_wdata = {j_inc_idx, hi_r};
          sp_nxt   = sp_r + EXT_W'(1);
        end
      end
      ST_EMIT_RD: begin
        st_raddr_a = k_r[IDX_W-1:0];
      end
      ST_EMIT_LD: begin
        out_vld_nxt  = 1'b1;
        out_val_nxt  = st_rdata_a;
        out_last_nxt = (k_r == cnt_dec);
        out_ovf_nxt  = drop_r;
      end
      ST_EMIT_OUT: begin
        if (out_fire) begin
          out_vld_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt  = '0;
            drop_nxt = 1'b0;
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      sp_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      sp_r      <= sp_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Indices and data; no reset needed.
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    key_r      <= key_nxt;
    tmp_r      <= tmp_nxt;
    k_r        <= k_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Loading and replay never overlap.
  a_load_vs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_vld_r))
    else $error("input accepted while a result is pending");

  // The store count stays within the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STORE_DEPTH))
    else $error("item count beyond store depth");

  // Disjoint ranges of two or more bound the stack depth.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= EXT_W'(STORE_DEPTH / 2))
    else $error("range stack deeper than expected");

  // The j pointer never scans below the pivot slot.
  a_j_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_EV) |-> (j_r >= lo_r))
    else $error("scan pointer j below range");

  // The final result transfer clears the set.
  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_r) |=> (cnt_r == '0 && !drop_r && in_ch.ready))
    else $error("set not cleared after final result");

endmodule

`default_nettype wire
